[design/bffa_pkg.sv]
package bffa_pkg;

  localparam int CAPACITY_DEF = 8192;
  localparam logic [13:0] TOTAL_RST = 14'd8192;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [13:0] entry_number;
  } in_item_t;

  typedef struct packed {
    logic [13:0] allocated_number;
    logic [1:0]  status;
    logic [13:0] free_count;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_DONE
  } state_t;

endpackage

[design/bitmap_first_fit_allocator.sv]
// Allocate: the scan reads one 32-bit bitmap word per cycle, from word 0 up to the
// word holding the first free entry (at most word WORDS - 1), then S_DONE registers
// the result. Free: S_FREE then S_DONE; out of range: straight to S_DONE.
// One item in progress at a time: the next is accepted in the cycle after the
// result is registered; a result held by out_stall holds back the next one.
// Reset clears all WORDS bitmap words, one word per cycle, input stalled.
module bitmap_first_fit_allocator
  import bffa_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [13:0] cfg_wdata
);

  localparam int WORDS = (CAPACITY + 31) / 32;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int EW    = (CW > 14) ? CW : 14;
  localparam int LW    = ((EW > AW + 5) ? EW : AW + 5) + 1;
  localparam logic [AW-1:0] LAST = AW'(WORDS - 1);

  logic [31:0] mem [WORDS];
  logic [31:0] mem_rd_r;
  logic        mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [31:0] mem_wd;

  state_t state_r, state_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic [AW-1:0] chk_addr_r, chk_addr_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [13:0] res_num_r, res_num_nxt;
  logic [1:0]  res_status_r, res_status_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [13:0] total_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;

  logic [EW-1:0] eff;
  logic [LW-1:0] eff_x, base_x, diff_x;
  logic [31:0] valid_mask, cand, onehot;
  logic [4:0]  idx;
  logic        last_word;
  logic [13:0] fr_idx;
  logic [AW-1:0] fr_word;
  logic [AW-1:0] rd_inc;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_r <= mem[mem_ra];
  end

  always_comb begin
    eff = (EW'(total_r) > EW'(CAPACITY)) ? EW'(CAPACITY) : EW'(total_r);
    eff_x = LW'(eff);
    base_x = LW'({chk_addr_r, 5'd0});
    diff_x = eff_x - base_x;
    if (eff_x <= base_x) begin
      valid_mask = '0;
    end else if (diff_x >= LW'(32)) begin
      valid_mask = '1;
    end else begin
      valid_mask = ~(32'hFFFF_FFFF << diff_x[4:0]);
    end
    last_word = (eff_x <= base_x + LW'(32));
    cand = ~mem_rd_r & valid_mask;
    onehot = cand & (~cand + 32'd1);
    for (int k = 0; k < 5; k++) begin
      idx[k] = 1'b0;
      for (int b = 0; b < 32; b++) begin
        if (((b >> k) & 1) == 1) begin
          idx[k] = idx[k] | onehot[b];
        end
      end
    end
    fr_idx = in_item.entry_number - 14'd1;
    fr_word = AW'(fr_idx >> 5);
    rd_inc = (rd_addr_r == LAST) ? rd_addr_r : rd_addr_r + AW'(1);
  end

  always_comb begin
    state_nxt      = state_r;
    rd_addr_nxt    = rd_addr_r;
    chk_addr_nxt   = chk_addr_r;
    pos_nxt        = pos_r;
    res_num_nxt    = res_num_r;
    res_status_nxt = res_status_r;
    used_nxt       = used_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_item_nxt   = out_item_r;
    mem_we         = 1'b0;
    mem_wa         = chk_addr_r;
    mem_wd         = '0;
    mem_ra         = rd_addr_r;
    in_stall       = 1'b1;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = rd_addr_r;
        if (rd_addr_r == LAST) begin
          state_nxt = S_IDLE;
        end else begin
          rd_addr_nxt = rd_addr_r + AW'(1);
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        mem_ra = (in_item.operation == OP_ALLOC) ? '0 : fr_word;
        if (in_valid) begin
          res_num_nxt    = '0;
          res_status_nxt = ST_OK;
          if (in_item.operation == OP_ALLOC) begin
            chk_addr_nxt = '0;
            rd_addr_nxt  = (LAST == '0) ? '0 : AW'(1);
            state_nxt    = S_SCAN;
          end else if (in_item.entry_number == '0 ||
                       EW'(in_item.entry_number) > eff) begin
            res_status_nxt = ST_RANGE;
            state_nxt      = S_DONE;
          end else begin
            chk_addr_nxt = fr_word;
            pos_nxt      = fr_idx[4:0];
            state_nxt    = S_FREE;
          end
        end
      end
      S_SCAN: begin
        mem_ra       = rd_addr_r;
        chk_addr_nxt = rd_addr_r;
        rd_addr_nxt  = rd_inc;
        if (cand != '0) begin
          mem_we      = 1'b1;
          mem_wd      = mem_rd_r | onehot;
          res_num_nxt = 14'(base_x + LW'(idx) + LW'(1));
          if (used_r != CW'(CAPACITY)) begin
            used_nxt = used_r + CW'(1);
          end
          state_nxt = S_DONE;
        end else if (last_word) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_DONE;
        end
      end
      S_FREE: begin
        mem_we = 1'b1;
        mem_wd = mem_rd_r & ~(32'd1 << pos_r);
        if (used_r != '0) begin
          used_nxt = used_r - CW'(1);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                 = 1'b1;
          out_item_nxt.allocated_number = res_num_r;
          out_item_nxt.status           = res_status_r;
          out_item_nxt.free_count       = (eff > EW'(used_r)) ?
                                          14'(eff - EW'(used_r)) : '0;
          state_nxt                     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      rd_addr_r   <= '0;
      used_r      <= '0;
      total_r     <= TOTAL_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_addr_r   <= rd_addr_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        total_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r   <= chk_addr_nxt;
    pos_r        <= pos_nxt;
    res_num_r    <= res_num_nxt;
    res_status_r <= res_status_nxt;
    out_item_r   <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
